// File: rtl/dbc_pkg.sv
// Package for the token scanner: field widths, token kinds, error codes,
// scan modes and small byte classifiers. No dependencies.
package dbc_pkg;

	localparam int MaxTokenLength = 4095;
	localparam int PositionBits = 32;
	localparam int LenBits = 12;

	localparam logic [4:0] KIND_EOS = 5'd0;
	localparam logic [4:0] KIND_EOL = 5'd1;
	localparam logic [4:0] KIND_IDENT = 5'd2;
	localparam logic [4:0] KIND_INT = 5'd3;
	localparam logic [4:0] KIND_REAL = 5'd4;
	localparam logic [4:0] KIND_STRING = 5'd5;
	localparam logic [4:0] KIND_OP0 = 5'd6;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_UNKNOWN = 3'd1;
	localparam logic [2:0] ERR_NO_DDIG = 3'd2;
	localparam logic [2:0] ERR_NO_EDIG = 3'd3;
	localparam logic [2:0] ERR_NO_QUOTE = 3'd4;
	localparam logic [2:0] ERR_NO_MARK = 3'd5;
	localparam logic [2:0] ERR_BAD_MARK = 3'd6;

	localparam logic [2:0] REG_ESC_START = 3'd0;
	localparam logic [2:0] REG_MARK0 = 3'd1;
	localparam logic [2:0] REG_MARK1 = 3'd2;
	localparam logic [2:0] REG_MARK2 = 3'd3;
	localparam logic [2:0] REG_MARK3 = 3'd4;
	localparam logic [2:0] REG_MARK_CNT = 3'd5;

	typedef enum logic [1:0] {
		MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_STRING
	} mode_t;

	// One report: kind, error, position, length.
	typedef struct packed {
		logic [4:0] kind;
		logic [2:0] err;
		logic [PositionBits-1:0] pos;
		logic [LenBits-1:0] len;
	} report_t;

	// Escape configuration handed to the scanner.
	typedef struct packed {
		logic [7:0] esc_start;
		logic [7:0] mark0;
		logic [7:0] mark1;
		logic [7:0] mark2;
		logic [7:0] mark3;
		logic [2:0] mark_cnt;
	} esc_cfg_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_ident_start(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
	endfunction

	// Operator index 0..10, 11 when the byte is no operator.
	function automatic logic [3:0] op_index(input logic [7:0] c);
		case (c)
			8'h3A: return 4'd0;
			8'h2C: return 4'd1;
			8'h40: return 4'd2;
			8'h28: return 4'd3;
			8'h5B: return 4'd4;
			8'h2D: return 4'd5;
			8'h2B: return 4'd6;
			8'h29: return 4'd7;
			8'h5D: return 4'd8;
			8'h3B: return 4'd9;
			8'h7C: return 4'd10;
			default: return 4'd11;
		endcase
	endfunction

endpackage

// File: rtl/dbc_cfg_regs.sv
// Escape configuration registers behind the APB-style port.
// Depends on dbc_pkg.
module dbc_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output dbc_pkg::esc_cfg_t cfg
);
	logic wr;
	logic [2:0] idx;
	assign wr = psel && penable && pwrite;
	assign idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.esc_start <= 8'd92;
			cfg.mark0 <= 8'd34;
			cfg.mark1 <= 8'd92;
			cfg.mark2 <= 8'd110;
			cfg.mark3 <= 8'd116;
			cfg.mark_cnt <= 3'd2;
		end else if (wr) begin
			case (idx)
				dbc_pkg::REG_ESC_START: cfg.esc_start <= pwdata[7:0];
				dbc_pkg::REG_MARK0: cfg.mark0 <= pwdata[7:0];
				dbc_pkg::REG_MARK1: cfg.mark1 <= pwdata[7:0];
				dbc_pkg::REG_MARK2: cfg.mark2 <= pwdata[7:0];
				dbc_pkg::REG_MARK3: cfg.mark3 <= pwdata[7:0];
				dbc_pkg::REG_MARK_CNT: cfg.mark_cnt <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			dbc_pkg::REG_ESC_START: prdata = {24'd0, cfg.esc_start};
			dbc_pkg::REG_MARK0: prdata = {24'd0, cfg.mark0};
			dbc_pkg::REG_MARK1: prdata = {24'd0, cfg.mark1};
			dbc_pkg::REG_MARK2: prdata = {24'd0, cfg.mark2};
			dbc_pkg::REG_MARK3: prdata = {24'd0, cfg.mark3};
			dbc_pkg::REG_MARK_CNT: prdata = {29'd0, cfg.mark_cnt};
			default: prdata = 32'd0;
		endcase
	end
endmodule

// File: rtl/dbc_scan_core.sv
// Scanner state and per-byte next-state logic; yields up to two reports
// per accepted word. Depends on dbc_pkg.
module dbc_scan_core (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [7:0] c,
	input  logic eoi,
	input  dbc_pkg::esc_cfg_t cfg,
	output logic [1:0] n_rep,
	output dbc_pkg::report_t rep0,
	output dbc_pkg::report_t rep1,
	output dbc_pkg::report_t rep2
);
	localparam int PB = dbc_pkg::PositionBits;
	localparam int LB = dbc_pkg::LenBits;
	localparam logic [LB-1:0] MaxLen = LB'(dbc_pkg::MaxTokenLength);

	dbc_pkg::mode_t mode_q, mode_d;
	logic sep_q, ddig_q, exp_q, esgn_q, edig_q;
	logic sep_d, ddig_d, exp_d, esgn_d, edig_d;
	logic point_q, point_d, escp_q, escp_d, err_q, err_d;
	logic [PB-1:0] start_q, start_d, off_q, off_d;
	logic [LB-1:0] cnt_q, cnt_d, cnt_inc;

	dbc_pkg::report_t reps[3];
	logic [1:0] n;

	assign cnt_inc = (cnt_q < MaxLen) ? cnt_q + 1'b1 : cnt_q;
	assign rep0 = reps[0];
	assign rep1 = reps[1];
	assign rep2 = reps[2];
	assign n_rep = n;

	always_comb begin
		logic [7:0] cb;
		logic ismark, ext, disp, numok;
		logic [2:0] mc;
		logic [3:0] oi;
		cb = c;
		mode_d = mode_q;
		{sep_d, ddig_d, exp_d, esgn_d, edig_d} = {sep_q, ddig_q, exp_q, esgn_q, edig_q};
		point_d = point_q;
		escp_d = escp_q;
		err_d = err_q;
		start_d = start_q;
		cnt_d = cnt_q;
		off_d = off_q;
		n = 2'd0;
		disp = 1'b0;
		ext = 1'b0;
		numok = 1'b1;
		for (int i = 0; i < 3; i++) reps[i] = '0;
		mc = (cfg.mark_cnt > 3'd4) ? 3'd4 : cfg.mark_cnt;
		ismark = (mc > 3'd0 && cb == cfg.mark0) || (mc > 3'd1 && cb == cfg.mark1) ||
			(mc > 3'd2 && cb == cfg.mark2) || (mc > 3'd3 && cb == cfg.mark3);
		oi = dbc_pkg::op_index(cb);
		if (step && !err_q) begin
			if (eoi) begin
				if (point_q) begin
					point_d = 1'b0;
					reps[0] = '{dbc_pkg::KIND_EOS, dbc_pkg::ERR_UNKNOWN, start_q, LB'(1)};
					n = 2'd1;
					err_d = 1'b1;
					numok = 1'b0;
				end else if (mode_q == dbc_pkg::MODE_IDENT) begin
					reps[0] = '{dbc_pkg::KIND_IDENT, dbc_pkg::ERR_NONE, start_q, cnt_q};
					n = 2'd1;
				end else if (mode_q == dbc_pkg::MODE_NUMBER) begin
					n = 2'd1;
					if (sep_q && !ddig_q) begin
						reps[0] = '{dbc_pkg::KIND_EOS, dbc_pkg::ERR_NO_DDIG, start_q, cnt_q};
						err_d = 1'b1;
						numok = 1'b0;
					end else if (exp_q && !edig_q) begin
						reps[0] = '{dbc_pkg::KIND_EOS, dbc_pkg::ERR_NO_EDIG, start_q, cnt_q};
						err_d = 1'b1;
						numok = 1'b0;
					end else begin
						reps[0] = '{(sep_q || exp_q) ? dbc_pkg::KIND_REAL : dbc_pkg::KIND_INT,
							dbc_pkg::ERR_NONE, start_q, cnt_q};
					end
				end else if (mode_q == dbc_pkg::MODE_STRING) begin
					reps[0] = '{dbc_pkg::KIND_EOS,
						escp_q ? dbc_pkg::ERR_NO_MARK : dbc_pkg::ERR_NO_QUOTE, start_q, cnt_q};
					n = 2'd1;
					err_d = 1'b1;
					numok = 1'b0;
				end
				mode_d = dbc_pkg::MODE_IDLE;
				escp_d = 1'b0;
				if (numok) begin
					reps[n] = '{dbc_pkg::KIND_EOS, dbc_pkg::ERR_NONE, off_q, LB'(0)};
					n = n + 2'd1;
				end
			end else begin
				off_d = off_q + 1'b1;
				if (point_q) begin
					point_d = 1'b0;
					if (dbc_pkg::is_digit(cb)) begin
						mode_d = dbc_pkg::MODE_NUMBER;
						{sep_d, ddig_d, exp_d, esgn_d, edig_d} = 5'b11000;
						cnt_d = cnt_inc;
					end else begin
						reps[0] = '{dbc_pkg::KIND_EOS, dbc_pkg::ERR_UNKNOWN, start_q, LB'(1)};
						n = 2'd1;
						err_d = 1'b1;
					end
				end else if (mode_q == dbc_pkg::MODE_IDENT) begin
					if (dbc_pkg::is_ident_start(cb) || dbc_pkg::is_digit(cb)) begin
						cnt_d = cnt_inc;
					end else begin
						mode_d = dbc_pkg::MODE_IDLE;
						reps[0] = '{dbc_pkg::KIND_IDENT, dbc_pkg::ERR_NONE, start_q, cnt_q};
						n = 2'd1;
						disp = 1'b1;
					end
				end else if (mode_q == dbc_pkg::MODE_NUMBER) begin
					if (cb == 8'h2E) begin
						ext = !(sep_q || exp_q);
						if (ext) sep_d = 1'b1;
					end else if (dbc_pkg::is_digit(cb)) begin
						ext = 1'b1;
						if (exp_q) edig_d = 1'b1;
						else if (sep_q) ddig_d = 1'b1;
					end else if (cb == 8'h65 || cb == 8'h45) begin
						ext = !(exp_q || (sep_q && !ddig_q));
						if (ext) exp_d = 1'b1;
					end else if (cb == 8'h2B || cb == 8'h2D) begin
						ext = exp_q && !(esgn_q || edig_q);
						if (ext) esgn_d = 1'b1;
					end
					if (ext) begin
						cnt_d = cnt_inc;
					end else begin
						mode_d = dbc_pkg::MODE_IDLE;
						n = 2'd1;
						if (sep_q && !ddig_q) begin
							reps[0] = '{dbc_pkg::KIND_EOS, dbc_pkg::ERR_NO_DDIG, start_q, cnt_q};
							err_d = 1'b1;
						end else if (exp_q && !edig_q) begin
							reps[0] = '{dbc_pkg::KIND_EOS, dbc_pkg::ERR_NO_EDIG, start_q, cnt_q};
							err_d = 1'b1;
						end else begin
							reps[0] = '{(sep_q || exp_q) ? dbc_pkg::KIND_REAL : dbc_pkg::KIND_INT,
								dbc_pkg::ERR_NONE, start_q, cnt_q};
							disp = 1'b1;
						end
					end
				end else if (mode_q == dbc_pkg::MODE_STRING) begin
					if (escp_q) begin
						escp_d = 1'b0;
						if (ismark) begin
							cnt_d = cnt_inc;
						end else begin
							reps[0] = '{dbc_pkg::KIND_EOS, dbc_pkg::ERR_BAD_MARK, start_q, cnt_q};
							n = 2'd1;
							err_d = 1'b1;
							mode_d = dbc_pkg::MODE_IDLE;
						end
					end else if (cb == cfg.esc_start) begin
						escp_d = 1'b1;
						cnt_d = cnt_inc;
					end else begin
						cnt_d = cnt_inc;
						if (cb == 8'h22) begin
							mode_d = dbc_pkg::MODE_IDLE;
							reps[0] = '{dbc_pkg::KIND_STRING, dbc_pkg::ERR_NONE, start_q, cnt_inc};
							n = 2'd1;
						end
					end
				end else begin
					disp = 1'b1;
				end
				// Start of a new token, or a one-byte token, at this byte; blanks are skipped and an unknown byte is an error.
				if (disp) begin
					if (cb == 8'h09 || cb == 8'h20 || cb == 8'h0D) begin
					end else if (cb == 8'h0A) begin
						reps[n] = '{dbc_pkg::KIND_EOL, dbc_pkg::ERR_NONE, off_q, LB'(1)};
						n = n + 2'd1;
					end else if (dbc_pkg::is_ident_start(cb)) begin
						mode_d = dbc_pkg::MODE_IDENT;
						start_d = off_q;
						cnt_d = LB'(1);
					end else if (dbc_pkg::is_digit(cb)) begin
						mode_d = dbc_pkg::MODE_NUMBER;
						{sep_d, ddig_d, exp_d, esgn_d, edig_d} = 5'b0;
						start_d = off_q;
						cnt_d = LB'(1);
					end else if (cb == 8'h2E) begin
						point_d = 1'b1;
						start_d = off_q;
						cnt_d = LB'(1);
					end else if (cb == 8'h22) begin
						mode_d = dbc_pkg::MODE_STRING;
						escp_d = 1'b0;
						start_d = off_q;
						cnt_d = LB'(1);
					end else if (oi != 4'd11) begin
						reps[n] = '{dbc_pkg::KIND_OP0 + 5'(oi), dbc_pkg::ERR_NONE, off_q, LB'(1)};
						n = n + 2'd1;
					end else begin
						reps[n] = '{dbc_pkg::KIND_EOS, dbc_pkg::ERR_UNKNOWN, off_q, LB'(1)};
						n = n + 2'd1;
						err_d = 1'b1;
						mode_d = dbc_pkg::MODE_IDLE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= dbc_pkg::MODE_IDLE;
			{sep_q, ddig_q, exp_q, esgn_q, edig_q} <= 5'b0;
			point_q <= 1'b0;
			escp_q <= 1'b0;
			err_q <= 1'b0;
			start_q <= '0;
			cnt_q <= '0;
			off_q <= '0;
		end else begin
			mode_q <= mode_d;
			{sep_q, ddig_q, exp_q, esgn_q, edig_q} <= {sep_d, ddig_d, exp_d, esgn_d, edig_d};
			point_q <= point_d;
			escp_q <= escp_d;
			err_q <= err_d;
			start_q <= start_d;
			cnt_q <= cnt_d;
			off_q <= off_d;
		end
	end
endmodule

// File: rtl/dbc_out_queue.sv
// Result buffer: holds up to three reports of one word plus those of the
// next and drains them one per cycle while out_ready is high. Depends on dbc_pkg.
module dbc_out_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [1:0] n_push,
	input  dbc_pkg::report_t rep0,
	input  dbc_pkg::report_t rep1,
	input  dbc_pkg::report_t rep2,
	output logic room,
	output logic out_valid,
	input  logic out_ready,
	output dbc_pkg::report_t out_rep,
	output logic out_last
);
	// Eight entries, each a report plus its end-of-run flag.
	logic [dbc_pkg::PositionBits+dbc_pkg::LenBits+8:0] mem_q [8];
	logic [2:0] rd_q, wr_q;
	logic [3:0] fill_q;
	logic pop;
	logic [3:0] fill_d;

	assign pop = out_valid && out_ready;
	assign out_valid = fill_q != 4'd0;
	assign {out_rep, out_last} = mem_q[rd_q];
	// Room for a full word of three after what may still be waiting.
	assign room = fill_q <= 4'd5;
	assign fill_d = fill_q + (push ? {2'b0, n_push} : 4'd0) - {3'b0, pop};

	always_ff @(posedge clk) begin
		if (push) begin
			if (n_push > 2'd0) mem_q[wr_q] <= {rep0, n_push == 2'd1};
			if (n_push > 2'd1) mem_q[wr_q + 3'd1] <= {rep1, n_push == 2'd2};
			if (n_push > 2'd2) mem_q[wr_q + 3'd2] <= {rep2, 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + {1'b0, n_push};
			if (pop) rd_q <= rd_q + 3'd1;
			fill_q <= fill_d;
		end
	end
endmodule

// File: rtl/dbc_token_scanner_top.sv
// Top level of the CAN database text token scanner.
// Depends on dbc_pkg, dbc_cfg_regs, dbc_scan_core and dbc_out_queue.
//
//   channel   | direction | handshake       | contents
//   s_axis    | in        | tvalid/tready   | tdata: char_in; tuser: end_of_input
//   m_axis    | out       | tvalid/tready   | tdata: kind, error, position, length; tlast
//   apb       | in        | psel/penable    | six escape configuration registers
//
// Each accepted word is scanned in the cycle it arrives; its zero to two
// reports enter an eight-entry result buffer and leave one per cycle while m_axis_tready is high.
// A byte is taken every cycle while the buffer has room for three more
// reports, so a steady stream of one report per byte runs at full rate.
// Reset clears all scan state, the buffer and the registers to defaults.
// A stalled output only stops input once the buffer holds six or more reports.
module dbc_token_scanner_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_in
	input  logic s_axis_tuser,         // [0] end_of_input
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [4:0] token_kind, [7:5] error_code, [39:8] start_position,
	// [51:40] token_length, [55:52] zero fill
	output logic [55:0] m_axis_tdata,
	output logic m_axis_tlast,         // last_of_run
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	dbc_pkg::esc_cfg_t cfg;
	dbc_pkg::report_t rep0, rep1, rep2, out_rep;
	logic [1:0] n_rep;
	logic step, room;

	assign pready = 1'b1;
	assign s_axis_tready = room;
	assign step = s_axis_tvalid && room;

	dbc_cfg_regs u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
	);

	dbc_scan_core u_core (
		.clk, .arst_n, .step, .c(s_axis_tdata), .eoi(s_axis_tuser), .cfg,
		.n_rep, .rep0, .rep1, .rep2
	);

	dbc_out_queue u_queue (
		.clk, .arst_n, .push(step), .n_push(n_rep), .rep0, .rep1, .rep2, .room,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rep,
		.out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {4'd0, out_rep.len, out_rep.pos, out_rep.err, out_rep.kind};
endmodule

// File: rtl/dbc_checker.sv
// Port-level checks for the token scanner, bound to the top level.
// Depends on dbc_token_scanner_top only through its ports.
module dbc_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic m_axis_tlast,
	input logic pready
);
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled word changed");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[4:0] <= 5'd16 && m_axis_tdata[7:5] <= 3'd6)
		else $error("bad kind or error code");
	a_errkind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[7:5] != 3'd0 |-> m_axis_tdata[4:0] == 5'd0
		&& m_axis_tlast)
		else $error("error report malformed");
	// Input is only held off while reports are waiting to leave.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid)
		else $error("input blocked with an empty buffer");
endmodule

bind dbc_token_scanner_top dbc_checker u_chk (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
	.m_axis_tdata, .m_axis_tlast, .pready
);
